[src/atf_pkg.sv]
// ----------------------------------------------------------------------------
// atf_pkg
// Shared types, constants and ring arithmetic for the array tour flip engine.
// ----------------------------------------------------------------------------
package atf_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VTX_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int KIND_W       = 3;
   localparam int STEP_W       = $clog2(VTX_W);

   localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUCC    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PRED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BETWEEN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLIP    = 3'd4;

   localparam logic [SIZE_W-1:0] RING_MIN = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] RING_MAX = SIZE_W'(MAX_VERTICES);

   typedef logic [VTX_W-1:0] vtx_type;

   typedef struct packed {
      logic    ord_we;
      vtx_type ord_waddr;
      vtx_type ord_wdata;
      vtx_type ord_raddr0;
      vtx_type ord_raddr1;
      logic    plc_we;
      vtx_type plc_waddr;
      vtx_type plc_wdata;
      vtx_type plc_raddr0;
      vtx_type plc_raddr1;
   } store_cmd_type;

   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v < RING_MIN) r = RING_MIN;
      if (v > RING_MAX) r = RING_MAX;
      return r;
   endfunction

   function automatic vtx_type inc_wrap(input vtx_type p, input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0] s;
      s = {1'b0, p} + SIZE_W'(1);
      if (s >= n) s = s - n;
      return s[VTX_W-1:0];
   endfunction

   function automatic vtx_type dec_wrap(input vtx_type p, input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0] s;
      s = (p == '0) ? (n - SIZE_W'(1)) : ({1'b0, p} - SIZE_W'(1));
      return s[VTX_W-1:0];
   endfunction

   // forward steps from position pu to position pw
   function automatic vtx_type ring_gap(input vtx_type pu, input vtx_type pw,
                                        input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0] g;
      g = {1'b0, pw} + n - {1'b0, pu};
      if (g >= n) g = g - n;
      return g[VTX_W-1:0];
   endfunction

endpackage

[src/atf_rem_unit.sv]
// ----------------------------------------------------------------------------
// atf_rem_unit
// Restoring remainder unit: one dividend bit per cycle, reduces a stored
// position modulo the ring length.
// ----------------------------------------------------------------------------
module atf_rem_unit import atf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vtx_type           dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output vtx_type           remainder
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   vtx_type           rem_ff;
   vtx_type           dvd_ff;
   logic [SIZE_W-1:0] dsr_ff;
   logic [SIZE_W-1:0] trial;
   vtx_type           rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[VTX_W-1]};
      rem_in = (trial >= dsr_ff) ? VTX_W'(trial - dsr_ff) : trial[VTX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= STEP_W'(VTX_W - 1);
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - STEP_W'(1);
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[VTX_W-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[src/atf_store.sv]
// ----------------------------------------------------------------------------
// atf_store
// Tour order and vertex place memories: one write and two registered reads
// per memory per cycle.
// ----------------------------------------------------------------------------
module atf_store import atf_pkg::*; (
   input  logic          clock,
   input  store_cmd_type cmd,
   output vtx_type       ord_rdata0,
   output vtx_type       ord_rdata1,
   output vtx_type       plc_rdata0,
   output vtx_type       plc_rdata1
);

   vtx_type ord_mem [MAX_VERTICES];
   vtx_type plc_mem [MAX_VERTICES];
   vtx_type ord_rd0_ff;
   vtx_type ord_rd1_ff;
   vtx_type plc_rd0_ff;
   vtx_type plc_rd1_ff;

   always_ff @(posedge clock) begin
      if (cmd.ord_we) begin
         ord_mem[cmd.ord_waddr] <= cmd.ord_wdata;
      end
      ord_rd0_ff <= ord_mem[cmd.ord_raddr0];
      ord_rd1_ff <= ord_mem[cmd.ord_raddr1];
   end

   always_ff @(posedge clock) begin
      if (cmd.plc_we) begin
         plc_mem[cmd.plc_waddr] <= cmd.plc_wdata;
      end
      plc_rd0_ff <= plc_mem[cmd.plc_raddr0];
      plc_rd1_ff <= plc_mem[cmd.plc_raddr1];
   end

   assign ord_rdata0 = ord_rd0_ff;
   assign ord_rdata1 = ord_rd1_ff;
   assign plc_rdata0 = plc_rd0_ff;
   assign plc_rdata1 = plc_rd1_ff;

endmodule

[src/array_tour_flip_engine_core.sv]
// ----------------------------------------------------------------------------
// array_tour_flip_engine_core
// Array-based tour with load, successor, predecessor, between and 2-opt flip
// operations, one item at a time, state held in two memories.
// ----------------------------------------------------------------------------
// operation: load and unknown kinds go straight to the result; every vertex
// position lookup is a place read plus a 10-step remainder; successor and
// predecessor do one lookup then an order read, between three lookups, flip
// four lookups then an order read, place read and two writes per swapped pair;
// throughput: one item in flight, next item taken when the previous finishes
// reset: synchronous, clears the sequencer and output beat, tour size to 1024
// ----------------------------------------------------------------------------
module array_tour_flip_engine_core import atf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   // position, vertex_a, vertex_b, vertex_c, vertex_d, zero pad
   input  logic [55:0]       req_tdata,
   // kind
   input  logic [2:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // answer_vertex, is_between, zero pad
   output logic [15:0]       rsp_tdata
);

   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_FETCH_RD    = 4'd1;
   localparam logic [3:0] ST_FETCH_START = 4'd2;
   localparam logic [3:0] ST_FETCH_DIV   = 4'd3;
   localparam logic [3:0] ST_Q_RD        = 4'd4;
   localparam logic [3:0] ST_Q_CAP       = 4'd5;
   localparam logic [3:0] ST_CALC        = 4'd6;
   localparam logic [3:0] ST_PLAN        = 4'd7;
   localparam logic [3:0] ST_SW_ORD      = 4'd8;
   localparam logic [3:0] ST_SW_PLC      = 4'd9;
   localparam logic [3:0] ST_SW_WR1      = 4'd10;
   localparam logic [3:0] ST_SW_WR2      = 4'd11;
   localparam logic [3:0] ST_DONE        = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [SIZE_W-1:0] ring_n_ff;
   logic [KIND_W-1:0] kind_ff;
   vtx_type           vtx_ff [4];
   vtx_type           spot_ff [4];
   logic [1:0]        k_ff;
   logic [1:0]        k_last;
   vtx_type           ans_ff;
   vtx_type           gap0_ff, gap1_ff;
   vtx_type           p1_ff, p2_ff;
   vtx_type           cnt_ff;
   vtx_type           v1_ff, v2_ff;
   vtx_type           t1_ff;
   logic              rsp_valid_ff;
   vtx_type           rsp_ans_ff;
   logic              rsp_btw_ff;

   store_cmd_type     cmd;
   vtx_type           ord_rdata0, ord_rdata1, plc_rdata0, plc_rdata1;
   logic              rem_start, rem_done;
   vtx_type           rem_value;

   logic              req_fire;
   logic              rsp_load;
   logic              take_ac;
   vtx_type           plan_len;
   logic [SIZE_W-1:0] plan_cnt;

   atf_store u_store (
      .clock      (clock),
      .cmd        (cmd),
      .ord_rdata0 (ord_rdata0),
      .ord_rdata1 (ord_rdata1),
      .plc_rdata0 (plc_rdata0),
      .plc_rdata1 (plc_rdata1)
   );

   atf_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (plc_rdata0),
      .divisor   (ring_n_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rem_start  = (state_ff == ST_FETCH_START);

   always_comb begin
      unique case (kind_ff)
         KIND_BETWEEN: k_last = 2'd2;
         KIND_FLIP:    k_last = 2'd3;
         default:      k_last = 2'd0;
      endcase
   end

   // shorter side of the 2-opt move, a..c on a tie
   always_comb begin
      take_ac  = (gap0_ff <= gap1_ff);
      plan_len = take_ac ? gap0_ff : gap1_ff;
      plan_cnt = ({1'b0, plan_len} + SIZE_W'(1)) >> 1;
   end

   always_comb begin
      cmd            = '0;
      cmd.plc_raddr0 = vtx_ff[k_ff];
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ord_we    = req_fire && (req_tuser == KIND_LOAD);
            cmd.ord_waddr = req_tdata[9:0];
            cmd.ord_wdata = req_tdata[19:10];
            cmd.plc_we    = req_fire && (req_tuser == KIND_LOAD);
            cmd.plc_waddr = req_tdata[19:10];
            cmd.plc_wdata = req_tdata[9:0];
         end
         ST_Q_RD: begin
            cmd.ord_raddr0 = (kind_ff == KIND_SUCC) ? inc_wrap(spot_ff[0], ring_n_ff)
                                                    : dec_wrap(spot_ff[0], ring_n_ff);
         end
         ST_SW_ORD: begin
            cmd.ord_raddr0 = p1_ff;
            cmd.ord_raddr1 = p2_ff;
         end
         ST_SW_PLC: begin
            cmd.plc_raddr0 = ord_rdata0;
            cmd.plc_raddr1 = ord_rdata1;
         end
         ST_SW_WR1: begin
            cmd.ord_we    = 1'b1;
            cmd.ord_waddr = p1_ff;
            cmd.ord_wdata = v2_ff;
            cmd.plc_we    = 1'b1;
            cmd.plc_waddr = v1_ff;
            cmd.plc_wdata = plc_rdata1;
         end
         ST_SW_WR2: begin
            cmd.ord_we    = 1'b1;
            cmd.ord_waddr = p2_ff;
            cmd.ord_wdata = v1_ff;
            cmd.plc_we    = 1'b1;
            cmd.plc_waddr = v2_ff;
            cmd.plc_wdata = t1_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_SUCC || req_tuser == KIND_PRED ||
                   req_tuser == KIND_BETWEEN || req_tuser == KIND_FLIP) begin
                  state_in = ST_FETCH_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH_RD:    state_in = ST_FETCH_START;
         ST_FETCH_START: state_in = ST_FETCH_DIV;
         ST_FETCH_DIV: begin
            if (rem_done) begin
               if (k_ff != k_last) begin
                  state_in = ST_FETCH_RD;
               end else if (kind_ff == KIND_SUCC || kind_ff == KIND_PRED) begin
                  state_in = ST_Q_RD;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_Q_RD:  state_in = ST_Q_CAP;
         ST_Q_CAP: state_in = ST_DONE;
         ST_CALC:  state_in = (kind_ff == KIND_FLIP) ? ST_PLAN : ST_DONE;
         ST_PLAN:  state_in = (plan_cnt == '0) ? ST_DONE : ST_SW_ORD;
         ST_SW_ORD: state_in = ST_SW_PLC;
         ST_SW_PLC: state_in = ST_SW_WR1;
         ST_SW_WR1: state_in = ST_SW_WR2;
         ST_SW_WR2: state_in = (cnt_ff == VTX_W'(1)) ? ST_DONE : ST_SW_ORD;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ring_n_ff    <= RING_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            ring_n_ff <= sat_size(csr_wdata);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff   <= req_tuser;
         vtx_ff[0] <= req_tdata[19:10];
         vtx_ff[1] <= req_tdata[29:20];
         vtx_ff[2] <= req_tdata[39:30];
         vtx_ff[3] <= req_tdata[49:40];
         k_ff      <= 2'd0;
         ans_ff    <= '0;
      end
      if (state_ff == ST_FETCH_DIV && rem_done) begin
         spot_ff[k_ff] <= rem_value;
         k_ff          <= k_ff + 2'd1;
      end
      if (state_ff == ST_Q_CAP) begin
         ans_ff <= ord_rdata0;
      end
      if (state_ff == ST_CALC) begin
         gap0_ff <= ring_gap(spot_ff[0], spot_ff[2], ring_n_ff);
         gap1_ff <= (kind_ff == KIND_BETWEEN) ? ring_gap(spot_ff[0], spot_ff[1], ring_n_ff)
                                              : ring_gap(spot_ff[3], spot_ff[1], ring_n_ff);
      end
      if (state_ff == ST_PLAN) begin
         p1_ff  <= take_ac ? spot_ff[0] : spot_ff[3];
         p2_ff  <= take_ac ? spot_ff[2] : spot_ff[1];
         cnt_ff <= plan_cnt[VTX_W-1:0];
      end
      if (state_ff == ST_SW_PLC) begin
         v1_ff <= ord_rdata0;
         v2_ff <= ord_rdata1;
      end
      if (state_ff == ST_SW_WR1) begin
         t1_ff <= plc_rdata0;
      end
      if (state_ff == ST_SW_WR2) begin
         p1_ff  <= inc_wrap(p1_ff, ring_n_ff);
         p2_ff  <= dec_wrap(p2_ff, ring_n_ff);
         cnt_ff <= cnt_ff - VTX_W'(1);
      end
      if (rsp_load) begin
         rsp_ans_ff <= (kind_ff == KIND_SUCC || kind_ff == KIND_PRED) ? ans_ff : '0;
         rsp_btw_ff <= (kind_ff == KIND_BETWEEN) && (gap1_ff < gap0_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_btw_ff, rsp_ans_ff};

endmodule

[src/atf_checker.sv]
// ----------------------------------------------------------------------------
// atf_checker
// Port-level checks for the array tour flip engine, bound to the top level.
// ----------------------------------------------------------------------------
module atf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result beat keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one item in flight: no second request right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in flight");

   // only one result field is ever nonzero, pad bits stay clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == 5'd0 &&
                     !(rsp_tdata[10] && rsp_tdata[9:0] != 10'd0))
      else $error("malformed result beat");

   // after reset the engine is idle with no result pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("engine not idle after reset");

endmodule

bind array_tour_flip_engine_core atf_checker u_atf_checker (.*);

[verif/array_tour_flip_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// array_tour_flip_engine_core_tb
// Self-checking bench for the array tour flip engine. A full 1024-vertex tour
// is loaded first so that every store entry holds a value. Directed queries
// and flips follow, then tour sizes at and beyond their limits, an output
// hold-off that backs up the input, and random phases on freshly loaded tours
// of many sizes. A local tour model predicts every result beat, and the
// result stream is compared against it field by field.
// ----------------------------------------------------------------------------
module array_tour_flip_engine_core_tb;
   import atf_pkg::*;

   // kinds the block takes but ignores
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   typedef struct {
      vtx_type answer_vertex;
      logic    is_between;
   } tour_reply_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   // position, vertex_a, vertex_b, vertex_c, vertex_d, zero pad
   logic [55:0]       req_tdata;
   // kind
   logic [2:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // answer_vertex, is_between, zero pad
   logic [15:0]       rsp_tdata;

   // local copy of the tour and the size register
   vtx_type           order_tbl [MAX_VERTICES];
   vtx_type           place_tbl [MAX_VERTICES];
   logic [SIZE_W-1:0] tour_len_reg;

   tour_reply_type    expected_replies [$];
   int                error_count = 0;
   int                vertex_pool [MAX_VERTICES];
   bit                req_idle_on = 1'b1;
   bit                rsp_idle_on = 1'b1;
   int                rsp_hold_cycles = 0;

   array_tour_flip_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int live_size();
      int n;
      n = tour_len_reg;
      if (n < 3) n = 3;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      return n;
   endfunction

   function automatic int tour_spot(input vtx_type v, input int n);
      return int'(place_tbl[v]) % n;
   endfunction

   function automatic int forward_steps(input vtx_type u, input vtx_type w, input int n);
      int g;
      g = tour_spot(w, n) + n - tour_spot(u, n);
      if (g >= n) g -= n;
      return g;
   endfunction

   function automatic tour_reply_type step_tour(input logic [KIND_W-1:0] kind,
                                                input vtx_type pos, input vtx_type a,
                                                input vtx_type b, input vtx_type c,
                                                input vtx_type d);
      tour_reply_type r;
      int             n, p, gac, gdb, lo_pos, hi_pos, span, p1, p2;
      vtx_type        v1, v2, t;
      n = live_size();
      r.answer_vertex = '0;
      r.is_between = 1'b0;
      case (kind)
         KIND_LOAD: begin
            order_tbl[pos] = a;
            place_tbl[a] = pos;
         end
         KIND_SUCC: begin
            p = tour_spot(a, n) + 1;
            if (p >= n) p -= n;
            r.answer_vertex = order_tbl[p];
         end
         KIND_PRED: begin
            p = tour_spot(a, n) + n - 1;
            if (p >= n) p -= n;
            r.answer_vertex = order_tbl[p];
         end
         KIND_BETWEEN: begin
            r.is_between = forward_steps(a, b, n) < forward_steps(a, c, n);
         end
         KIND_FLIP: begin
            gac = forward_steps(a, c, n);
            gdb = forward_steps(d, b, n);
            // reverse the shorter side, a..c when both are equal
            if (gac <= gdb) begin
               lo_pos = tour_spot(a, n);
               hi_pos = tour_spot(c, n);
               span = gac;
            end else begin
               lo_pos = tour_spot(d, n);
               hi_pos = tour_spot(b, n);
               span = gdb;
            end
            for (int i = 0; i < (span + 1) / 2; i++) begin
               p1 = lo_pos + i;
               p2 = hi_pos + n - i;
               if (p1 >= n) p1 -= n;
               if (p2 >= n) p2 -= n;
               v1 = order_tbl[p1];
               v2 = order_tbl[p2];
               order_tbl[p1] = v2;
               order_tbl[p2] = v1;
               t = place_tbl[v1];
               place_tbl[v1] = place_tbl[v2];
               place_tbl[v2] = t;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
      error_count++;
   endtask

   always @(posedge clock) begin : reply_check
      tour_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("result beat with nothing pending", 0, int'(rsp_tdata));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata[VTX_W-1:0] != want.answer_vertex)
               report_mismatch("answer_vertex", int'(want.answer_vertex),
                               int'(rsp_tdata[VTX_W-1:0]));
            if (rsp_tdata[VTX_W] != want.is_between)
               report_mismatch("is_between", int'(want.is_between), int'(rsp_tdata[VTX_W]));
         end
      end
   end

   // result side: random stalls plus a long hold-off on request
   initial begin : result_sink
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic vtx_type any_vertex();
      return vtx_type'($urandom_range(0, MAX_VERTICES - 1));
   endfunction

   function automatic vtx_type at_pos(input int p);
      return order_tbl[p];
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input vtx_type pos,
                            input vtx_type a, input vtx_type b, input vtx_type c,
                            input vtx_type d);
      int             gap;
      tour_reply_type reply;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, d, c, b, a, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reply = step_tour(kind, pos, a, b, c, d);
      expected_replies.insert(expected_replies.size(), reply);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_tour_size(input logic [SIZE_W-1:0] value);
      wait_results_done();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tour_len_reg = value;
   endtask

   // positions 0..n-1 get n distinct random vertices
   task automatic load_tour(input int n);
      int j, t;
      for (int i = 0; i < MAX_VERTICES; i++) vertex_pool[i] = i;
      for (int i = MAX_VERTICES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = vertex_pool[i];
         vertex_pool[i] = vertex_pool[j];
         vertex_pool[j] = t;
      end
      for (int p = 0; p < n; p++)
         send_item(KIND_LOAD, vtx_type'(p), vtx_type'(vertex_pool[p]),
                   any_vertex(), any_vertex(), any_vertex());
   endtask

   task automatic send_noise_item();
      send_item(KIND_W'($urandom_range(KIND_SUCC, KIND_FLIP)), any_vertex(),
                any_vertex(), any_vertex(), any_vertex(), any_vertex());
   endtask

   // mostly well-formed queries and moves on tour members, some noise
   task automatic random_tour_item(input int n);
      int sel, i, j, k;
      sel = $urandom_range(0, 99);
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      k = $urandom_range(0, n - 1);
      if (sel < 15)
         send_item(KIND_SUCC, any_vertex(), at_pos(i), any_vertex(), any_vertex(),
                   any_vertex());
      else if (sel < 30)
         send_item(KIND_PRED, any_vertex(), at_pos(i), any_vertex(), any_vertex(),
                   any_vertex());
      else if (sel < 50)
         send_item(KIND_BETWEEN, any_vertex(), at_pos(i), at_pos(j), at_pos(k),
                   any_vertex());
      else if (sel < 75)
         send_item(KIND_FLIP, any_vertex(), at_pos(i), at_pos((i + n - 1) % n),
                   at_pos(j), at_pos((j + 1) % n));
      else if (sel < 78)
         send_item(KIND_LOAD, any_vertex(), any_vertex(), any_vertex(), any_vertex(),
                   any_vertex());
      else if (sel < 94)
         send_noise_item();
      else
         send_item(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                   any_vertex(), any_vertex(), any_vertex(), any_vertex(), any_vertex());
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_full_load();
      load_tour(MAX_VERTICES);
   endtask

   task automatic test_directed_ops();
      vtx_type ones;
      ones = '1;
      // neighbours across the wrap and inside the ring
      send_item(KIND_SUCC, '0, at_pos(1023), '0, '0, '0);
      send_item(KIND_PRED, '0, at_pos(0), '0, '0, '0);
      send_item(KIND_SUCC, ones, at_pos(500), ones, ones, ones);
      send_item(KIND_PRED, '0, at_pos(1), '0, '0, '0);
      // between: ordered, reversed, middle equals start, end equals start,
      // middle equals end, and a walk through position zero
      send_item(KIND_BETWEEN, '0, at_pos(10), at_pos(20), at_pos(30), '0);
      send_item(KIND_BETWEEN, '0, at_pos(10), at_pos(30), at_pos(20), '0);
      send_item(KIND_BETWEEN, '0, at_pos(5), at_pos(5), at_pos(6), '0);
      send_item(KIND_BETWEEN, '0, at_pos(5), at_pos(6), at_pos(5), '0);
      send_item(KIND_BETWEEN, '0, at_pos(5), at_pos(9), at_pos(9), '0);
      send_item(KIND_BETWEEN, '0, at_pos(1020), at_pos(2), at_pos(8), '0);
      // ignored kinds, all ones and all zeros
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
         send_item(KIND_W'(k), ones, ones, ones, ones, ones);
      send_item(KIND_SPARE_FIRST, '0, '0, '0, '0, '0);
      // flips: empty path, path across the wrap, d..b shorter, equal sides
      send_item(KIND_FLIP, '0, at_pos(100), at_pos(99), at_pos(100), at_pos(101));
      send_item(KIND_FLIP, '0, at_pos(1022), at_pos(1021), at_pos(3), at_pos(4));
      send_item(KIND_SUCC, '0, at_pos(1022), '0, '0, '0);
      send_item(KIND_FLIP, '0, at_pos(10), at_pos(9), at_pos(1015), at_pos(1016));
      send_item(KIND_PRED, '0, at_pos(9), '0, '0, '0);
      send_item(KIND_FLIP, '0, at_pos(0), at_pos(1023), at_pos(511), at_pos(512));
      send_item(KIND_BETWEEN, '0, at_pos(0), at_pos(300), at_pos(511), '0);
      // reload the extreme positions with what they hold
      send_item(KIND_LOAD, ones, at_pos(1023), ones, ones, ones);
      send_item(KIND_LOAD, '0, at_pos(0), '0, '0, '0);
   endtask

   // sizes below and above the legal range, and stale places beyond the ring
   task automatic test_size_limits();
      logic [SIZE_W-1:0] sizes [6];
      sizes = '{11'd0, 11'd2, 11'd2047, 11'd1025, 11'd3, 11'd1024};
      foreach (sizes[s]) begin
         set_tour_size(sizes[s]);
         repeat (2) send_noise_item();
         send_item(KIND_SUCC, '0, any_vertex(), '0, '0, '0);
      end
   endtask

   task automatic test_output_backpressure();
      wait_results_done();
      rsp_hold_cycles = 300;
      // keep offering while results are held so the input stalls
      repeat (20) random_tour_item(live_size());
      wait_results_done();
   endtask

   task automatic test_random_tours();
      logic [SIZE_W-1:0] sizes [7];
      int                n;
      sizes = '{11'd3, 11'd4, 11'd5, 11'd8, 11'd13, 11'd37, 11'd6};
      foreach (sizes[ph]) begin
         set_tour_size(sizes[ph]);
         // last phase runs flat out on both sides
         if (ph == 6) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         n = live_size();
         load_tour(n);
         repeat (15) random_tour_item(n);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int waited;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      tour_len_reg = RING_MAX;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         order_tbl[i] = '0;
         place_tbl[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_load();
      test_directed_ops();
      test_size_limits();
      test_output_backpressure();
      test_random_tours();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_replies.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_replies.size() != 0)
         report_mismatch("results never delivered", 0, expected_replies.size());
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("array_tour_flip_engine_core_tb: clean");
      end else begin
         $display("array_tour_flip_engine_core_tb: errors");
      end
      $finish;
   end

   // far beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("array_tour_flip_engine_core_tb: errors");
      $finish;
   end

endmodule
